// ===== hw/rtl/itt_pkg.sv =====
// Package for the INI text tokenizer: parser states, result kinds, byte classes.
// No dependencies; used by every module of the tokenizer.
package itt_pkg;

  localparam int OFFSET_BITS_DEF = 16;
  localparam int QUEUE_DEPTH     = 4;
  localparam int OUT_W           = 16;

  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;
  localparam logic [7:0] CH_EQUALS  = 8'h3D;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_DEL     = 8'h7F;
  localparam logic [7:0] CH_NUL     = 8'h00;

  localparam logic [OUT_W-1:0] LINE_MAX = '1;

  typedef enum logic [2:0] {
    KIND_SECTION = 3'd0,
    KIND_KEY     = 3'd1,
    KIND_VALUE   = 3'd2,
    KIND_END     = 3'd3,
    KIND_ERROR   = 3'd4
  } itt_kind_e;

  typedef enum logic [3:0] {
    ST_LINE      = 4'd0,
    ST_SKIP      = 4'd1,
    ST_SEC_OPEN  = 4'd2,
    ST_SEC_NAME  = 4'd3,
    ST_SEC_BLANK = 4'd4,
    ST_SEC_DONE  = 4'd5,
    ST_KEY_NAME  = 4'd6,
    ST_KEY_BLANK = 4'd7,
    ST_VAL_START = 4'd8,
    ST_VAL_BODY  = 4'd9,
    ST_ERROR     = 4'd10
  } itt_state_e;

  typedef struct packed {
    logic eot;
    logic blank;
    logic cr;
    logic nl;
    logic term;
    logic lbrack;
    logic rbrack;
    logic equals;
    logic sec_ok;
    logic key_ok;
    logic val_bad;
  } itt_entry_t;

endpackage

// ===== hw/rtl/itt_front.sv =====
// Front end of the INI text tokenizer: classifies each accepted byte for the queue.
// Depends on itt_pkg.
module itt_front (
  input  logic              s_valid_i,
  input  logic              op_i,
  input  logic [7:0]        data_i,
  input  logic              q_full_i,
  output logic              s_ready_o,
  output logic              push_o,
  output itt_pkg::itt_entry_t entry_o
);

  logic letter, digit;

  assign letter = (data_i >= 8'h41 && data_i <= 8'h5A) || (data_i >= 8'h61 && data_i <= 8'h7A);
  assign digit  = (data_i >= 8'h30 && data_i <= 8'h39);

  always_comb begin
    entry_o.eot     = op_i || (data_i == itt_pkg::CH_NUL);
    entry_o.blank   = (data_i == itt_pkg::CH_SPACE) || (data_i == itt_pkg::CH_TAB);
    entry_o.cr      = (data_i == itt_pkg::CH_CR);
    entry_o.nl      = (data_i == itt_pkg::CH_NEWLINE);
    entry_o.term    = (data_i == itt_pkg::CH_NEWLINE) || (data_i == itt_pkg::CH_HASH) ||
                      (data_i == itt_pkg::CH_SEMI);
    entry_o.lbrack  = (data_i == itt_pkg::CH_LBRACK);
    entry_o.rbrack  = (data_i == itt_pkg::CH_RBRACK);
    entry_o.equals  = (data_i == itt_pkg::CH_EQUALS);
    entry_o.sec_ok  = data_i[7] || letter || (data_i == itt_pkg::CH_DOT) ||
                      (data_i == itt_pkg::CH_UNDER);
    entry_o.key_ok  = data_i[7] || letter || digit || (data_i == itt_pkg::CH_UNDER);
    entry_o.val_bad = (data_i < itt_pkg::CH_SPACE) || (data_i == itt_pkg::CH_DEL);
  end

  assign s_ready_o = !q_full_i;
  assign push_o    = s_valid_i && !q_full_i;

endmodule

// ===== hw/rtl/itt_queue.sv =====
// Short queue of classified bytes between front and back of the tokenizer.
// Depends on itt_pkg.
module itt_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  itt_pkg::itt_entry_t wdata_i,
  input  logic                pop_i,
  output itt_pkg::itt_entry_t rdata_o,
  output logic                valid_o,
  output logic                full_o
);

  localparam int PtrW = $clog2(itt_pkg::QUEUE_DEPTH);
  localparam int CntW = $clog2(itt_pkg::QUEUE_DEPTH + 1);
  localparam logic [CntW-1:0] Depth = CntW'(itt_pkg::QUEUE_DEPTH);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(itt_pkg::QUEUE_DEPTH - 1);

  itt_pkg::itt_entry_t mem_q [itt_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic do_pop;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == Depth);
  assign rdata_o = mem_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == LastIdx) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == LastIdx) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

// ===== hw/rtl/itt_back.sv =====
// Back end of the INI text tokenizer: parser state machine, counters, result register.
// Depends on itt_pkg.
module itt_back #(
  parameter int OffsetBits = itt_pkg::OFFSET_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  itt_pkg::itt_entry_t entry_i,
  input  logic                q_valid_i,
  output logic                pop_o,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  output itt_pkg::itt_kind_e  kind_o,
  output logic [itt_pkg::OUT_W-1:0] offset_o,
  output logic [itt_pkg::OUT_W-1:0] length_o,
  output logic [itt_pkg::OUT_W-1:0] line_o,
  output logic                last_o
);

  localparam int ExtW = (OffsetBits > itt_pkg::OUT_W) ? OffsetBits : itt_pkg::OUT_W;
  localparam logic [OffsetBits-1:0] OffMax = '1;

  itt_pkg::itt_state_e state_q, state_d;
  logic [OffsetBits-1:0] off_q, off_d, start_q, start_d, count_q, count_d, lnb_q, lnb_d;
  logic [itt_pkg::OUT_W-1:0] line_q, line_d;
  logic phase_q, phase_d;

  logic go, emit, e_last;
  itt_pkg::itt_kind_e e_kind;
  logic [OffsetBits-1:0] e_off, e_len;
  logic [itt_pkg::OUT_W-1:0] e_line;
  logic [ExtW-1:0] off_ext, len_ext;
  itt_pkg::itt_entry_t c;

  logic out_valid_q;
  itt_pkg::itt_kind_e out_kind_q;
  logic [itt_pkg::OUT_W-1:0] out_off_q, out_len_q, out_line_q;
  logic out_last_q;

  assign c  = entry_i;
  assign go = q_valid_i && (!out_valid_q || m_ready_i);

  always_comb begin
    state_d = state_q;
    off_d   = off_q;
    start_d = start_q;
    count_d = count_q;
    lnb_d   = lnb_q;
    line_d  = line_q;
    phase_d = phase_q;
    pop_o   = 1'b0;
    emit    = 1'b0;
    e_kind  = itt_pkg::KIND_END;
    e_off   = off_q;
    e_len   = '0;
    e_line  = line_q;
    e_last  = 1'b1;
    if (go) begin
      if (c.eot) begin
        if (state_q == itt_pkg::ST_SEC_DONE && !phase_q) begin
          emit    = 1'b1;
          e_kind  = itt_pkg::KIND_SECTION;
          e_off   = start_q;
          e_len   = count_q;
          e_last  = 1'b0;
          phase_d = 1'b1;
        end else begin
          pop_o = 1'b1;
          case (state_q)
            itt_pkg::ST_ERROR: begin
              emit = 1'b0;
            end
            itt_pkg::ST_LINE, itt_pkg::ST_SKIP, itt_pkg::ST_SEC_DONE: begin
              emit   = 1'b1;
              e_kind = itt_pkg::KIND_END;
            end
            default: begin
              emit   = 1'b1;
              e_kind = itt_pkg::KIND_ERROR;
            end
          endcase
          state_d = itt_pkg::ST_LINE;
          off_d   = '0;
          start_d = '0;
          count_d = '0;
          lnb_d   = '0;
          line_d  = '0;
          phase_d = 1'b0;
        end
      end else begin
        pop_o = 1'b1;
        if (state_q == itt_pkg::ST_ERROR) begin
          emit = 1'b0;
        end else if (off_q == OffMax) begin
          emit    = 1'b1;
          e_kind  = itt_pkg::KIND_ERROR;
          e_off   = OffMax;
          state_d = itt_pkg::ST_ERROR;
        end else begin
          case (state_q)
            itt_pkg::ST_LINE: begin
              if (!c.blank && !c.cr) begin
                if (line_q != itt_pkg::LINE_MAX) begin
                  line_d = line_q + 1'b1;
                end
                if (c.term) begin
                  state_d = c.nl ? itt_pkg::ST_LINE : itt_pkg::ST_SKIP;
                end else if (c.lbrack) begin
                  state_d = itt_pkg::ST_SEC_OPEN;
                end else if (c.key_ok) begin
                  start_d = off_q;
                  count_d = OffsetBits'(1);
                  state_d = itt_pkg::ST_KEY_NAME;
                end else begin
                  emit    = 1'b1;
                  e_kind  = itt_pkg::KIND_ERROR;
                  state_d = itt_pkg::ST_ERROR;
                end
              end
            end
            itt_pkg::ST_SKIP: begin
              if (c.nl) begin
                state_d = itt_pkg::ST_LINE;
              end
            end
            itt_pkg::ST_SEC_OPEN: begin
              if (!c.blank) begin
                if (c.sec_ok) begin
                  start_d = off_q;
                  count_d = OffsetBits'(1);
                  state_d = itt_pkg::ST_SEC_NAME;
                end else begin
                  emit    = 1'b1;
                  e_kind  = itt_pkg::KIND_ERROR;
                  state_d = itt_pkg::ST_ERROR;
                end
              end
            end
            itt_pkg::ST_SEC_NAME: begin
              if (c.blank) begin
                state_d = itt_pkg::ST_SEC_BLANK;
              end else if (c.rbrack) begin
                state_d = itt_pkg::ST_SEC_DONE;
              end else if (c.sec_ok) begin
                count_d = count_q + 1'b1;
              end else begin
                emit    = 1'b1;
                e_kind  = itt_pkg::KIND_ERROR;
                state_d = itt_pkg::ST_ERROR;
              end
            end
            itt_pkg::ST_SEC_BLANK: begin
              if (!c.blank) begin
                if (c.rbrack) begin
                  state_d = itt_pkg::ST_SEC_DONE;
                end else begin
                  emit    = 1'b1;
                  e_kind  = itt_pkg::KIND_ERROR;
                  state_d = itt_pkg::ST_ERROR;
                end
              end
            end
            itt_pkg::ST_SEC_DONE: begin
              if (c.term) begin
                emit    = 1'b1;
                e_kind  = itt_pkg::KIND_SECTION;
                e_off   = start_q;
                e_len   = count_q;
                state_d = c.nl ? itt_pkg::ST_LINE : itt_pkg::ST_SKIP;
              end else if (!c.blank) begin
                emit    = 1'b1;
                e_kind  = itt_pkg::KIND_ERROR;
                state_d = itt_pkg::ST_ERROR;
              end
            end
            itt_pkg::ST_KEY_NAME, itt_pkg::ST_KEY_BLANK: begin
              if (c.equals) begin
                emit    = 1'b1;
                e_kind  = itt_pkg::KIND_KEY;
                e_off   = start_q;
                e_len   = count_q;
                state_d = itt_pkg::ST_VAL_START;
              end else if (c.blank) begin
                state_d = itt_pkg::ST_KEY_BLANK;
              end else if (state_q == itt_pkg::ST_KEY_NAME && c.key_ok) begin
                count_d = count_q + 1'b1;
              end else begin
                emit    = 1'b1;
                e_kind  = itt_pkg::KIND_ERROR;
                state_d = itt_pkg::ST_ERROR;
              end
            end
            itt_pkg::ST_VAL_START: begin
              if (!c.blank) begin
                if (c.term) begin
                  emit    = 1'b1;
                  e_kind  = itt_pkg::KIND_VALUE;
                  e_off   = start_q;
                  state_d = c.nl ? itt_pkg::ST_LINE : itt_pkg::ST_SKIP;
                end else if (c.val_bad) begin
                  emit    = 1'b1;
                  e_kind  = itt_pkg::KIND_ERROR;
                  state_d = itt_pkg::ST_ERROR;
                end else begin
                  start_d = off_q;
                  lnb_d   = off_q;
                  state_d = itt_pkg::ST_VAL_BODY;
                end
              end
            end
            itt_pkg::ST_VAL_BODY: begin
              if (c.term) begin
                emit    = 1'b1;
                e_kind  = itt_pkg::KIND_VALUE;
                e_off   = start_q;
                e_len   = lnb_q + 1'b1 - start_q;
                state_d = c.nl ? itt_pkg::ST_LINE : itt_pkg::ST_SKIP;
              end else if (c.blank) begin
                lnb_d = lnb_q;
              end else if (c.val_bad) begin
                emit    = 1'b1;
                e_kind  = itt_pkg::KIND_ERROR;
                state_d = itt_pkg::ST_ERROR;
              end else begin
                lnb_d = off_q;
              end
            end
            default: begin
              state_d = itt_pkg::ST_ERROR;
            end
          endcase
          e_line = line_d;
          if (state_d != itt_pkg::ST_ERROR) begin
            off_d = off_q + 1'b1;
          end
        end
      end
    end
  end

  assign off_ext = ExtW'(e_off);
  assign len_ext = ExtW'(e_len);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= itt_pkg::ST_LINE;
      off_q       <= '0;
      start_q     <= '0;
      count_q     <= '0;
      lnb_q       <= '0;
      line_q      <= '0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      off_q   <= off_d;
      start_q <= start_d;
      count_q <= count_d;
      lnb_q   <= lnb_d;
      line_q  <= line_d;
      phase_q <= phase_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_kind_q <= e_kind;
      out_off_q  <= off_ext[itt_pkg::OUT_W-1:0];
      out_len_q  <= len_ext[itt_pkg::OUT_W-1:0];
      out_line_q <= e_line;
      out_last_q <= e_last;
    end
  end

  assign m_valid_o = out_valid_q;
  assign kind_o    = out_kind_q;
  assign offset_o  = out_off_q;
  assign length_o  = out_len_q;
  assign line_o    = out_line_q;
  assign last_o    = out_last_q;

endmodule

// ===== hw/rtl/ini_text_tokenizer.sv =====
// Top level of the INI text tokenizer: front classifier, byte queue, back parser.
// Depends on itt_pkg, itt_front, itt_queue and itt_back.
//
// Takes INI text one byte per word and returns section, key and value tokens as
// offset/length pairs with the current line number, then an end or error word
// per text. Sustained rate is one byte per cycle when the output is not stalled; the
// back-end parser state machine takes each byte from the queue. End of text after a
// complete section gives two results, the section and then the end, and holds the
// back end on that byte until the second; a four-entry queue absorbs output stalls.
module ini_text_tokenizer #(
  parameter int OffsetBits = itt_pkg::OFFSET_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [15:0] token_offset, [31:16] token_length,
                                      // [47:32] line_number
  output logic [2:0]  m_axis_tuser,   // [2:0] kind
  output logic        m_axis_tlast
);

  itt_pkg::itt_entry_t wr_entry, rd_entry;
  itt_pkg::itt_kind_e  kind;
  logic push, pop, q_valid, q_full;
  logic [itt_pkg::OUT_W-1:0] tok_off, tok_len, line_num;

  itt_front u_front (
    .s_valid_i (s_axis_tvalid),
    .op_i      (s_axis_tuser),
    .data_i    (s_axis_tdata),
    .q_full_i  (q_full),
    .s_ready_o (s_axis_tready),
    .push_o    (push),
    .entry_o   (wr_entry)
  );

  itt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wr_entry),
    .pop_i   (pop),
    .rdata_o (rd_entry),
    .valid_o (q_valid),
    .full_o  (q_full)
  );

  itt_back #(
    .OffsetBits (OffsetBits)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .entry_i   (rd_entry),
    .q_valid_i (q_valid),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .kind_o    (kind),
    .offset_o  (tok_off),
    .length_o  (tok_len),
    .line_o    (line_num),
    .last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {line_num, tok_len, tok_off};
  assign m_axis_tuser = kind;

  a_first_of_two_is_section : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser == itt_pkg::KIND_SECTION)
    else $error("non-last result is not a section");

  a_pair_ends_text : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      !m_axis_tvalid || (m_axis_tuser == itt_pkg::KIND_END && m_axis_tlast))
    else $error("section at end of text not followed by end result");

  a_error_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == itt_pkg::KIND_ERROR |-> m_axis_tlast)
    else $error("error result not last of run");

  a_end_len_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == itt_pkg::KIND_END ||
                      m_axis_tuser == itt_pkg::KIND_ERROR) |-> m_axis_tdata[31:16] == 16'd0)
    else $error("end or error result with nonzero length");

endmodule
